// ----- hw/rtl/nerw_pkg.sv -----
// Shared constants and types for the nearest-entry-within-radius search block.
`timescale 1ns / 1ps

package nerw_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 24;

  // Fixed field widths of the word format
  localparam int INDEX_WIDTH  = 6;
  localparam int RADIUS_WIDTH = 23;

  // Word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Tag that travels with each scanned entry through the distance pipeline
  typedef struct packed {
    logic live;   // a scan slot is in flight
    logic flag;   // entry valid flag read from the table
    logic last;   // final entry of the scan
  } scan_tag_t;

endpackage

// ----- hw/rtl/nerw_dist.sv -----
// Four-stage squared-distance pipeline: |diff|, square, two partial sums.
`timescale 1ns / 1ps

module nerw_dist #(
  parameter int COORD_WIDTH = nerw_pkg::COORD_WIDTH_DEF,
  parameter int ADDR_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nerw_pkg::scan_tag_t           tag_in,
  input  logic [ADDR_W-1:0]             addr_in,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  input  logic signed [COORD_WIDTH-1:0] qz,
  input  logic signed [COORD_WIDTH-1:0] ex,
  input  logic signed [COORD_WIDTH-1:0] ey,
  input  logic signed [COORD_WIDTH-1:0] ez,
  output nerw_pkg::scan_tag_t           tag_out,
  output logic [ADDR_W-1:0]             addr_out,
  output logic [2*(COORD_WIDTH+1)+1:0]  d2
);
  import nerw_pkg::*;

  localparam int DW = COORD_WIDTH + 1;   // magnitude of a difference
  localparam int QW = 2 * DW;            // one square
  localparam int SW = QW + 2;            // sum of three squares

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0] ax, ay, az;
  logic [QW-1:0] sqx, sqy, sqz, sqz_d;
  logic [QW:0]   sxy;
  scan_tag_t     tag1, tag2, tag3;
  logic [ADDR_W-1:0] addr1, addr2, addr3;

  assign dx = {qx[COORD_WIDTH-1], qx} - {ex[COORD_WIDTH-1], ex};
  assign dy = {qy[COORD_WIDTH-1], qy} - {ey[COORD_WIDTH-1], ey};
  assign dz = {qz[COORD_WIDTH-1], qz} - {ez[COORD_WIDTH-1], ez};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag3    <= '0;
      tag_out <= '0;
    end else begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag3    <= tag2;
      tag_out <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: magnitudes
    ax    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    az    <= dz[DW-1] ? DW'(-dz) : DW'(dz);
    addr1 <= addr_in;
    // stage 2: squares
    sqx   <= QW'(ax) * QW'(ax);
    sqy   <= QW'(ay) * QW'(ay);
    sqz   <= QW'(az) * QW'(az);
    addr2 <= addr1;
    // stage 3: x + y
    sxy   <= (QW+1)'(sqx) + (QW+1)'(sqy);
    sqz_d <= sqz;
    addr3 <= addr2;
    // stage 4: + z (never overflows SW bits)
    d2       <= SW'(sxy) + SW'(sqz_d);
    addr_out <= addr3;
  end

endmodule

// ----- hw/rtl/nearest_entry_within_radius.sv -----
// Top level of the nearest-entry-within-radius search block.
`timescale 1ns / 1ps

// Keeps a table of TABLE_DEPTH entries (valid flag + signed Q20.4 x/y/z) in
// two single-port-write, registered-read memories. A write word (kind 0)
// stores one entry and gives no result; a slot at or beyond TABLE_DEPTH
// is dropped. A query word (kind 1) scans the table one entry a cycle
// through a four-stage squared-distance pipeline and returns the valid
// entry with the smallest squared distance strictly below radius squared
// (the lowest index on ties), or found = 0 with nearest_index = 0.
// One word is in work at a time: a query occupies the block from acceptance
// until its result word is loaded, as the single table read port visits
// every entry; a write leaves the block idle. The result sits in an output
// register, so a new word is taken while an earlier result is still stalled.
// After reset the block clears all valid flags, one entry a cycle, and holds
// req_stall high until the sweep is done.
module nearest_entry_within_radius #(
  parameter int TABLE_DEPTH = nerw_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = nerw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                kind,
  input  logic [nerw_pkg::INDEX_WIDTH-1:0]    entry_index,
  input  logic                                entry_valid,
  input  logic signed [COORD_WIDTH-1:0]       pos_x,
  input  logic signed [COORD_WIDTH-1:0]       pos_y,
  input  logic signed [COORD_WIDTH-1:0]       pos_z,
  input  logic [nerw_pkg::RADIUS_WIDTH-1:0]   radius,
  // response channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                found,
  output logic [nerw_pkg::INDEX_WIDTH-1:0]    nearest_index
);
  import nerw_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW  = ((AW > INDEX_WIDTH) ? AW : INDEX_WIDTH) + 1;
  localparam int SW  = 2 * (COORD_WIDTH + 1) + 2;
  localparam int R2W = 2 * RADIUS_WIDTH;
  localparam int BW  = (SW > R2W) ? SW : R2W;
  localparam int PW  = 3 * COORD_WIDTH;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  // table storage
  logic          flag_mem [TABLE_DEPTH];
  logic [PW-1:0] pos_mem  [TABLE_DEPTH];

  logic          accept, wr_hit;
  logic          flag_we, flag_wd;
  logic [AW-1:0] flag_wa, wr_addr;
  logic          rd_en;

  // scan control
  logic [AW-1:0] cnt;
  logic          issuing;
  logic          rd_live, rd_last;
  logic [AW-1:0] rd_addr;
  logic          flag_rd;
  logic [PW-1:0] pos_rd;
  scan_tag_t     rd_tag, d_tag;
  logic [AW-1:0] d_addr;
  logic [SW-1:0] d2;

  // query context and running best
  logic signed [COORD_WIDTH-1:0] qx, qy, qz;
  logic [R2W-1:0] r2;
  logic [BW-1:0]  best;
  logic [AW-1:0]  best_idx;
  logic           best_found;
  logic           cmp_hit;
  logic [XW-1:0]  idx_wide;
  logic           rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign wr_addr   = AW'(entry_index);
  assign wr_hit    = accept && (kind == KIND_WRITE) &&
                     (XW'(entry_index) < XW'(TABLE_DEPTH));

  // flag port is shared by the post-reset clear sweep and table writes
  assign flag_we = wr_hit || (state == ST_CLEAR);
  assign flag_wa = (state == ST_CLEAR) ? cnt : wr_addr;
  assign flag_wd = (state == ST_CLEAR) ? 1'b0 : entry_valid;

  assign rd_en = (state == ST_SCAN) && issuing;

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (wr_hit) begin
      pos_mem[wr_addr] <= {pos_x, pos_y, pos_z};
    end
    if (rd_en) begin
      flag_rd <= flag_mem[cnt];
      pos_rd  <= pos_mem[cnt];
    end
  end

  assign rd_tag = '{live: rd_live, flag: flag_rd, last: rd_last};

  nerw_dist #(
    .COORD_WIDTH(COORD_WIDTH),
    .ADDR_W     (AW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .addr_in (rd_addr),
    .qx      (qx),
    .qy      (qy),
    .qz      (qz),
    .ex      (pos_rd[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .ey      (pos_rd[2*COORD_WIDTH-1:COORD_WIDTH]),
    .ez      (pos_rd[COORD_WIDTH-1:0]),
    .tag_out (d_tag),
    .addr_out(d_addr),
    .d2      (d2)
  );

  // strict less-than keeps the lowest index on equal distances
  assign cmp_hit = d_tag.live && d_tag.flag && (BW'(d2) < best);
  assign r2      = R2W'(radius) * R2W'(radius);
  assign idx_wide = XW'(best_idx);

  // result register free (or draining this cycle) while in finish
  assign rsp_load = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      issuing    <= 1'b0;
      rd_live    <= 1'b0;
      rd_last    <= 1'b0;
      best_found <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_live <= rd_en;
      rd_last <= rd_en && (cnt == LAST);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && (kind == KIND_QUERY)) begin
            cnt        <= '0;
            issuing    <= 1'b1;
            best_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            cnt <= cnt + 1'b1;
            if (cnt == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (cmp_hit) begin
            best_found <= 1'b1;
          end
          if (d_tag.live && d_tag.last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_addr <= cnt;
    if (accept && (kind == KIND_QUERY)) begin
      qx       <= pos_x;
      qy       <= pos_y;
      qz       <= pos_z;
      best     <= BW'(r2);
      best_idx <= '0;
    end else if ((state == ST_SCAN) && cmp_hit) begin
      best     <= BW'(d2);
      best_idx <= d_addr;
    end
    if (rsp_load) begin
      found         <= best_found;
      nearest_index <= best_found ? idx_wide[INDEX_WIDTH-1:0] : '0;
    end
  end

`ifndef SYNTH
  // a result word only appears out of the finish state
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_FINISH))
    else $error("response raised outside finish");

  // a not-found result always carries index zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !found) |-> (nearest_index == '0))
    else $error("not-found result with nonzero index");

  // the table is never written while a scan reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !flag_we)
    else $error("table write during scan");

  // the running best distance only shrinks within a scan
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && $past(state == ST_SCAN) && !$past(rst))
      |-> (best <= $past(best)))
    else $error("best distance grew during scan");

  // a scan ends only after all reads have been issued
  a_finish_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !issuing)
    else $error("finish reached with reads outstanding");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the nearest-entry-within-radius search block.
`timescale 1ns / 1ps

module testbench;
  import nerw_pkg::*;

  localparam int DEPTH   = TABLE_DEPTH_DEF;
  localparam int COORD_W = COORD_WIDTH_DEF;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [INDEX_WIDTH-1:0]    slot_t;
  typedef logic [RADIUS_WIDTH-1:0]   rad_t;

  // One request word as it crosses the request channel.
  typedef struct {
    logic   kind;
    slot_t  slot;
    logic   live;
    coord_t x;
    coord_t y;
    coord_t z;
    rad_t   rad;
  } req_word_t;

  // What one search should return.
  typedef struct packed {
    logic  hit;
    slot_t slot;
  } answer_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   req_valid = 1'b0;
  logic   req_stall;
  logic   kind = KIND_WRITE;
  slot_t  entry_index = '0;
  logic   entry_valid = 1'b0;
  coord_t pos_x = '0;
  coord_t pos_y = '0;
  coord_t pos_z = '0;
  rad_t   radius = '0;
  logic   rsp_valid;
  logic   rsp_stall = 1'b0;
  logic   found;
  slot_t  nearest_index;

  // Shadow copy of the table, updated as each word is accepted.
  logic   slot_live [DEPTH];
  coord_t slot_x [DEPTH];
  coord_t slot_y [DEPTH];
  coord_t slot_z [DEPTH];

  answer_t pending_answers[$];

  int gap_pct   = 0;  // chance in 100 that the sender idles a cycle
  int stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
  int n_errors  = 0;
  int n_writes  = 0;
  int n_searches = 0;
  int n_hits    = 0;

  nearest_entry_within_radius dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .entry_index   (entry_index),
    .entry_valid   (entry_valid),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .radius        (radius),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .found         (found),
    .nearest_index (nearest_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Exact search: squared distance against squared radius, strict less-than,
  // scanning upward so the lowest slot keeps any tie.
  function automatic answer_t closest_live_slot(input req_word_t w);
    answer_t ans;
    longint  best;
    longint  dx, dy, dz, d2;
    ans  = '0;
    best = longint'(w.rad) * longint'(w.rad);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_live[i]) begin
        dx = longint'(w.x) - longint'(slot_x[i]);
        dy = longint'(w.y) - longint'(slot_y[i]);
        dz = longint'(w.z) - longint'(slot_z[i]);
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < best) begin
          best     = d2;
          ans.hit  = 1'b1;
          ans.slot = slot_t'(i);
        end
      end
    end
    return ans;
  endfunction

  // Bookkeeping for an accepted word: table update or expected answer.
  task automatic take_word(input req_word_t w);
    answer_t ans;
    if (w.kind == KIND_WRITE) begin
      slot_live[w.slot] = w.live;
      slot_x[w.slot]    = w.x;
      slot_y[w.slot]    = w.y;
      slot_z[w.slot]    = w.z;
      n_writes++;
    end else begin
      ans = closest_live_slot(w);
      pending_answers.push_back(ans);
      n_searches++;
      if (ans.hit) n_hits++;
    end
  endtask

  // Drives one word; entered and left just after a rising edge.
  task automatic send_word(input req_word_t w);
    if ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_valid   <= 1'b1;
    kind        <= w.kind;
    entry_index <= w.slot;
    entry_valid <= w.live;
    pos_x       <= w.x;
    pos_y       <= w.y;
    pos_z       <= w.z;
    radius      <= w.rad;
    do @(posedge clk); while (req_stall);
    take_word(w);
  endtask

  function automatic req_word_t write_word(input int s, input logic lv,
                                           input coord_t x, input coord_t y,
                                           input coord_t z);
    req_word_t w;
    w.kind = KIND_WRITE;
    w.slot = slot_t'(s);
    w.live = lv;
    w.x    = x;
    w.y    = y;
    w.z    = z;
    w.rad  = rad_t'($urandom());
    return w;
  endfunction

  // Unused slot/flag fields of a search carry noise.
  function automatic req_word_t search_word(input coord_t x, input coord_t y,
                                            input coord_t z, input rad_t r);
    req_word_t w;
    w.kind = KIND_QUERY;
    w.slot = slot_t'($urandom());
    w.live = 1'($urandom());
    w.x    = x;
    w.y    = y;
    w.z    = z;
    w.rad  = r;
    return w;
  endfunction

  // Point within +/- spread of c; wraps at the coordinate width.
  function automatic coord_t jitter(input coord_t c, input int spread);
    return coord_t'(int'(c) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // Check each result word against the oldest waiting answer.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no search waiting: found=%0b nearest_index=%0d",
               found, nearest_index);
        n_errors++;
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.hit) begin
          $error("found: expected %0b, got %0b", want.hit, found);
          n_errors++;
        end
        if (nearest_index !== want.slot) begin
          $error("nearest_index: expected %0d, got %0d", want.slot, nearest_index);
          n_errors++;
        end
      end
    end
  end

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam rad_t   R_MAX = '1;

  // Nothing stored yet: even the widest radius finds nothing.
  task automatic test_empty_table();
    send_word(search_word(C_MIN, C_MAX, '0, R_MAX));
  endtask

  // Corner coordinates, widest and zero radius.
  task automatic test_extremes();
    send_word(write_word(DEPTH - 1, 1'b1, C_MAX, C_MAX, C_MAX));
    send_word(write_word(0, 1'b1, C_MIN, C_MIN, C_MIN));
    send_word(search_word(C_MIN, C_MIN, C_MAX, R_MAX));  // too far on z
    send_word(search_word(C_MAX, C_MAX, C_MAX, rad_t'(1)));
    send_word(search_word(C_MIN, C_MIN, C_MIN, '0));     // zero radius
    send_word(search_word(C_MIN, C_MIN, C_MIN, rad_t'(1)));
    send_word(search_word('0, '0, '0, R_MAX));
  endtask

  // Equal distances resolve to the lower slot; a cleared flag drops out.
  task automatic test_ties();
    send_word(write_word(9, 1'b1, 24'sd1000, -24'sd500, 24'sd77));
    send_word(write_word(5, 1'b1, 24'sd1000, -24'sd500, 24'sd77));
    send_word(search_word(24'sd1003, -24'sd500, 24'sd77, rad_t'(50)));
    send_word(write_word(12, 1'b1, 24'sd5010, 24'sd0, 24'sd0));
    send_word(write_word(11, 1'b1, 24'sd4990, 24'sd0, 24'sd0));
    send_word(search_word(24'sd5000, 24'sd0, 24'sd0, rad_t'(100)));
    send_word(write_word(5, 1'b0, 24'sd1000, -24'sd500, 24'sd77));
    send_word(search_word(24'sd1000, -24'sd500, 24'sd77, rad_t'(1)));
  endtask

  // Distance exactly equal to the radius is outside; one more is inside.
  task automatic test_radius_boundary();
    send_word(write_word(30, 1'b1, -24'sd48, 24'sd64, -24'sd9000));
    send_word(search_word('0, '0, -24'sd9000, rad_t'(80)));
    send_word(search_word('0, '0, -24'sd9000, rad_t'(81)));
  endtask

  // Clustered traffic so searches land near stored entries, with noise words.
  task automatic test_random_traffic(input int words, input int gap, input int stall);
    coord_t    cx, cy, cz;
    int        spread;
    int        pick;
    int        s;
    req_word_t w;
    gap_pct   = gap;
    stall_pct = stall;
    cx = '0;
    cy = '0;
    cz = '0;
    spread = 64;
    for (int n = 0; n < words; n++) begin
      if (n % 64 == 0) begin
        cx = coord_t'($urandom());
        cy = coord_t'($urandom());
        cz = coord_t'($urandom());
        case ($urandom_range(2))
          0: spread = 4;
          1: spread = 64;
          default: spread = 2000;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        // table write, mostly near the current cluster
        if ($urandom_range(99) < 80)
          w = write_word($urandom_range(DEPTH - 1), $urandom_range(99) < 85,
                         jitter(cx, spread), jitter(cy, spread), jitter(cz, spread));
        else
          w = write_word($urandom_range(DEPTH - 1), 1'($urandom()),
                         coord_t'($urandom()), coord_t'($urandom()),
                         coord_t'($urandom()));
      end else if (pick < 55) begin
        // search on or next to a stored entry, else at the cluster centre
        s = $urandom_range(DEPTH - 1);
        if (slot_live[s])
          w = search_word(jitter(slot_x[s], 2), jitter(slot_y[s], 2),
                          jitter(slot_z[s], 2), rad_t'($urandom_range(8)));
        else
          w = search_word(cx, cy, cz, rad_t'($urandom_range(3 * spread)));
      end else if (pick < 85) begin
        // search in the cluster with a radius of the cluster's scale
        w = search_word(jitter(cx, spread), jitter(cy, spread), jitter(cz, spread),
                        ($urandom_range(9) == 0) ? rad_t'(0)
                                                 : rad_t'($urandom_range(3 * spread)));
      end else begin
        // anything at all
        w = search_word(coord_t'($urandom()), coord_t'($urandom()),
                        coord_t'($urandom()), rad_t'($urandom()));
      end
      send_word(w);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_live[i] = 1'b0;
      slot_x[i]    = '0;
      slot_y[i]    = '0;
      slot_z[i]    = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_extremes();
    test_ties();
    test_radius_boundary();
    test_random_traffic(610, 10, 71);
    test_random_traffic(610, 71, 10);
    test_random_traffic(610, 0, 0);

    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("Ran %0d table writes and %0d searches (%0d hits), with sender gaps",
             n_writes, n_searches, n_hits);
    $display("and receiver back-pressure swapped between phases, then none.");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/nerw_pkg.sv
hw/rtl/nerw_dist.sv
hw/rtl/nearest_entry_within_radius.sv
tb/testbench.sv
